FILE: hw/rtl/rgbds_pkg.sv
// ----------------------------------------------------------------------------
// rgbds_pkg
// Shared widths, register indexes and reset values for the RGB565 2x2 box
// downsampler and its channel interfaces.
// ----------------------------------------------------------------------------
package rgbds_pkg;

   // Pixel format and field layout.
   localparam int PIXEL_WIDTH = 16;
   localparam int RED_LSB     = 11;
   localparam int RED_MSB     = 15;
   localparam int GREEN_LSB   = 5;
   localparam int GREEN_MSB   = 10;
   localparam int BLUE_LSB    = 0;
   localparam int BLUE_MSB    = 4;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 11;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT = 4'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [CSR_DATA_WIDTH-1:0] IMAGE_HEIGHT_RESET = 11'd480;

   // Frame geometry limits.
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int ROW_WIDTH         = 10;
   localparam logic [CSR_DATA_WIDTH-1:0] HEIGHT_LIMIT = 11'd1024;

endpackage

FILE: hw/rtl/rgbds_ifs.sv
// ----------------------------------------------------------------------------
// rgbds channel interfaces
// Valid/ready channels for source pixels, averaged pixels and register writes.
// ----------------------------------------------------------------------------

// Source pixel request channel.
interface rgbds_req_if;
   logic                               valid;
   logic                               ready;
   logic [rgbds_pkg::PIXEL_WIDTH-1:0]  pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

// Averaged pixel response channel.
interface rgbds_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rgbds_pkg::PIXEL_WIDTH-1:0]  pixel_out;
   logic                               row_last;
   logic                               frame_last;

   modport source (output valid, output pixel_out, output row_last, output frame_last,
                   input ready);
   modport sink   (input valid, input pixel_out, input row_last, input frame_last,
                   output ready);
endinterface

// Register write channel.
interface rgbds_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [rgbds_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [rgbds_pkg::CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/rgb565_box_downsample_2x.sv
// ----------------------------------------------------------------------------
// rgb565_box_downsample_2x
// Halves an RGB565 raster in both directions with a 2x2 box average.
// The request completing a block is registered in stage one, then its average in
// the output register. Throughput: one request per cycle while the output is not
// stalled, as each line store bank sees one access per cycle. Reset: sizes return
// to 640 x 480, the counters to the frame origin; the line store is not cleared.
// ----------------------------------------------------------------------------
module rgb565_box_downsample_2x #(
   parameter int MAX_WIDTH = rgbds_pkg::MAX_WIDTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   rgbds_req_if.sink    req_port,
   rgbds_rsp_if.source  rsp_port,
   rgbds_csr_if.sink    csr_port
);

   // The line store is split by column parity so that a block reads one entry
   // from each bank.
   localparam int BANK_DEPTH = MAX_WIDTH / 2;
   localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int CW = AW + 1;
   localparam int WW = (CW + 1 > rgbds_pkg::CSR_DATA_WIDTH) ? CW + 1
                                                           : rgbds_pkg::CSR_DATA_WIDTH;
   localparam logic [WW-1:0] WIDTH_LIMIT = WW'(MAX_WIDTH) & ~WW'(1);
   localparam int PW = rgbds_pkg::PIXEL_WIDTH;
   localparam int HW = rgbds_pkg::CSR_DATA_WIDTH;
   localparam int RW = rgbds_pkg::ROW_WIDTH;

   // Configuration registers.
   logic [HW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;

   // Raster position.
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [PW-1:0] left_ff, left_in;

   // Line store banks and their registered read data.
   logic [PW-1:0] even_bank [BANK_DEPTH];
   logic [PW-1:0] odd_bank  [BANK_DEPTH];
   logic [PW-1:0] even_rd_ff;
   logic [PW-1:0] odd_rd_ff;

   // Stage one: block waiting for its upper pair from the banks.
   logic          s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_pix_ff;
   logic [PW-1:0] s1_left_ff;
   logic          s1_row_last_ff;
   logic          s1_frame_last_ff;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_pixel_ff;
   logic          rsp_row_last_ff;
   logic          rsp_frame_last_ff;

   logic [WW-1:0] width_raw;
   logic [WW-1:0] eff_width;
   logic [HW-1:0] height_raw;
   logic [HW-1:0] eff_height;
   logic [CW:0]   col_plus;
   logic [RW:0]   row_plus;
   logic          end_row;
   logic          end_frame;
   logic          accept;
   logic          is_result;
   logic [AW-1:0] bank_addr;
   logic          advance;
   logic          stage1_free;

   // Sum four fields of one colour and drop the two low bits.
   function automatic logic [PW-1:0] quad_average(
      input logic [PW-1:0] a,
      input logic [PW-1:0] b,
      input logic [PW-1:0] c,
      input logic [PW-1:0] d
   );
      logic [6:0] red_sum;
      logic [7:0] green_sum;
      logic [6:0] blue_sum;
      red_sum   = 7'(a[15:11]) + 7'(b[15:11]) + 7'(c[15:11]) + 7'(d[15:11]);
      green_sum = 8'(a[10:5]) + 8'(b[10:5]) + 8'(c[10:5]) + 8'(d[10:5]);
      blue_sum  = 7'(a[4:0]) + 7'(b[4:0]) + 7'(c[4:0]) + 7'(d[4:0]);
      return {red_sum[6:2], green_sum[7:2], blue_sum[6:2]};
   endfunction

   // Effective frame size: even, at least two, width within the line store, height within HEIGHT_LIMIT.
   always_comb begin
      width_raw = WW'(width_ff) & ~WW'(1);
      if (width_raw < WW'(2)) begin
         eff_width = WW'(2);
      end else if (width_raw > WIDTH_LIMIT) begin
         eff_width = WIDTH_LIMIT;
      end else begin
         eff_width = width_raw;
      end
      height_raw = height_ff & ~HW'(1);
      if (height_raw < HW'(2)) begin
         eff_height = HW'(2);
      end else if (height_raw > rgbds_pkg::HEIGHT_LIMIT) begin
         eff_height = rgbds_pkg::HEIGHT_LIMIT;
      end else begin
         eff_height = height_raw;
      end
   end

   // Row and frame ends use ">=" so that a shrunken size ends the row at once.
   assign col_plus  = {1'b0, col_ff} + (CW+1)'(1);
   assign row_plus  = {1'b0, row_ff} + (RW+1)'(1);
   assign end_row   = WW'(col_plus) >= eff_width;
   assign end_frame = end_row && (HW'(row_plus) >= eff_height);

   // Handshake and pipeline flow.
   assign advance      = !rsp_valid_ff || rsp_port.ready;
   assign stage1_free  = !s1_valid_ff || advance;
   assign req_port.ready = stage1_free;
   assign accept       = req_port.valid && stage1_free;
   assign is_result    = row_ff[0] && col_ff[0];
   assign bank_addr    = col_ff[AW:1];
   assign csr_port.ready = 1'b1;

   // Register writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_port.valid) begin
         case (csr_port.index)
            rgbds_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_port.data;
            rgbds_pkg::CSR_IMAGE_HEIGHT: height_in = csr_port.data;
            default: begin
            end
         endcase
      end
   end

   // Raster counters and the held lower-left pixel.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (accept) begin
         if (row_ff[0] && !col_ff[0]) begin
            left_in = req_port.pixel_in;
         end
         if (end_row) begin
            col_in = '0;
            row_in = end_frame ? '0 : row_plus[RW-1:0];
         end else begin
            col_in = col_plus[CW-1:0];
         end
      end
   end

   // Valid bits of the two stages.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (stage1_free) begin
         s1_valid_in = accept && is_result;
      end
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rgbds_pkg::IMAGE_WIDTH_RESET;
         height_ff    <= rgbds_pkg::IMAGE_HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Even rows fill the line store. Odd rows only read it, and every entry a
   // block reads was written at least one request earlier, so no forwarding
   // is needed.
   always_ff @(posedge clock) begin
      if (accept && !row_ff[0] && !col_ff[0]) begin
         even_bank[bank_addr] <= req_port.pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !row_ff[0] && col_ff[0]) begin
         odd_bank[bank_addr] <= req_port.pixel_in;
      end
   end

   // Upper pair read; held while the stage one block is stalled.
   always_ff @(posedge clock) begin
      if (stage1_free) begin
         even_rd_ff <= even_bank[bank_addr];
         odd_rd_ff  <= odd_bank[bank_addr];
      end
   end

   // Stage one payload: lower pair and flags.
   always_ff @(posedge clock) begin
      if (stage1_free) begin
         s1_pix_ff        <= req_port.pixel_in;
         s1_left_ff       <= left_ff;
         s1_row_last_ff   <= end_row;
         s1_frame_last_ff <= end_frame;
      end
   end

   // Output register: averaged block pixel.
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_pixel_ff      <= quad_average(even_rd_ff, odd_rd_ff, s1_left_ff, s1_pix_ff);
         rsp_row_last_ff   <= s1_row_last_ff;
         rsp_frame_last_ff <= s1_frame_last_ff;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.pixel_out  = rsp_pixel_ff;
   assign rsp_port.row_last   = rsp_row_last_ff;
   assign rsp_port.frame_last = rsp_frame_last_ff;

   // A request that completes a block always enters stage one.
   assert property (@(posedge clock) disable iff (reset)
      (accept && is_result) |=> s1_valid_ff)
      else $error("completed block did not enter stage one");

   // A stalled stage one block is neither lost nor replaced.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_pix_ff) && $stable(even_rd_ff)
                                     && $stable(odd_rd_ff)))
      else $error("stalled stage one block changed");

   // The frame end is always also a row end.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_frame_last_ff) |-> rsp_row_last_ff)
      else $error("frame end flagged without row end");

endmodule
